>>> rtl/pmqrl_pkg.sv
// Shared types and constants for the priority message queue with rate limit.
// Used by the controller, the datapath, the top level and the port checker.
package pmqrl_pkg;

   localparam int MAX_ENTRIES     = 16;
   localparam int IDX_W           = $clog2(MAX_ENTRIES);
   localparam int EVENT_DEPTH     = 8;
   localparam int EV_W            = $clog2(EVENT_DEPTH);
   localparam int MAX_FRAME_BYTES = 255;
   localparam int NUM_PRIORITIES  = 4;

   typedef enum logic [1:0] {
      ACT_ENQUEUE = 2'd0,
      ACT_TAKE    = 2'd1,
      ACT_POP     = 2'd2,
      ACT_NONE    = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_POLICY   = 3'd1,
      ST_ARG      = 3'd2,
      ST_LARGE    = 3'd3,
      ST_DUP      = 3'd4,
      ST_RATE     = 3'd5,
      ST_FULL     = 3'd6,
      ST_RESERVED = 3'd7
   } status_type;

   typedef enum logic [2:0] {
      CSR_CAPACITY    = 3'd0,
      CSR_RESERVED    = 3'd1,
      CSR_CLASS_MAP   = 3'd2,
      CSR_RATE_MAX    = 3'd3,
      CSR_RATE_WINDOW = 3'd4
   } csr_index_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_SCAN,
      S_DECIDE,
      S_TAKE,
      S_POP,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic load;
      logic check;
      logic scan;
      logic decide;
      logic take;
      logic pop;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic check_fail;
      logic scan_last;
      logic rsp_busy;
   } sts_type;

   typedef struct packed {
      logic        result_valid;
      status_type  status;
      logic [31:0] msg_id;
      logic [2:0]  msg_class;
      logic [1:0]  priority_lvl;
      logic [7:0]  frame_handle;
      logic [9:0]  frame_length;
      logic [63:0] created_ms;
      logic [63:0] expires_ms;
      logic        event_reason;
   } res_type;

endpackage

>>> rtl/pmqrl_ctrl.sv
// Sequencer for the priority message queue: steps each request through
// check, entry scan, decision, take or pop, and response. Depends on pmqrl_pkg.
module pmqrl_ctrl import pmqrl_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_action,
   input  sts_type    sts,
   output cmd_type    cmd
);

   state_type  state_ff, state_in;
   action_type act_ff, act_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         act_ff   <= ACT_NONE;
      end else begin
         state_ff <= state_in;
         act_ff   <= act_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      act_in    = act_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               act_in   = action_type'(req_action);
               case (action_type'(req_action))
                  ACT_ENQUEUE: state_in = S_CHECK;
                  ACT_TAKE:    state_in = S_SCAN;
                  ACT_POP:     state_in = S_POP;
                  default:     state_in = S_FINISH;
               endcase
            end
         end
         S_CHECK: begin
            cmd.check = 1'b1;
            state_in  = sts.check_fail ? S_FINISH : S_SCAN;
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.scan_last) begin
               state_in = (act_ff == ACT_ENQUEUE) ? S_DECIDE : S_TAKE;
            end
         end
         S_DECIDE: begin
            cmd.decide = 1'b1;
            state_in   = S_FINISH;
         end
         S_TAKE: begin
            cmd.take = 1'b1;
            state_in = S_FINISH;
         end
         S_POP: begin
            cmd.pop  = 1'b1;
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (!sts.rsp_busy) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

>>> rtl/pmqrl_dp.sv
// Datapath of the priority message queue: policy registers, entry table,
// rate windows, event ring and response register. Depends on pmqrl_pkg.
module pmqrl_dp import pmqrl_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output sts_type     sts,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata,
   input  logic [31:0] req_msg_id,
   input  logic [2:0]  req_message_class,
   input  logic [7:0]  req_frame_handle,
   input  logic [9:0]  req_frame_length,
   input  logic [63:0] req_now_ms,
   input  logic [31:0] req_lifetime_ms,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output res_type     rsp_res,
   output logic [4:0]  rsp_queued_count,
   output logic [3:0]  rsp_pending_events
);

   // policy registers
   logic [4:0]  cap_ff, rsv_ff;
   logic [11:0] map_ff;
   logic [31:0] rmax_ff;
   logic [63:0] rwin_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff  <= 5'd16;
         rsv_ff  <= 5'd0;
         map_ff  <= 12'd4068;
         rmax_ff <= '1;
         rwin_ff <= 64'd281479271743489000;
      end else if (csr_we) begin
         case (csr_index)
            CSR_CAPACITY:    cap_ff  <= csr_wdata[4:0];
            CSR_RESERVED:    rsv_ff  <= csr_wdata[4:0];
            CSR_CLASS_MAP:   map_ff  <= csr_wdata[11:0];
            CSR_RATE_MAX:    rmax_ff <= csr_wdata[31:0];
            CSR_RATE_WINDOW: rwin_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // request registers
   logic [31:0] id_ff;
   logic [2:0]  cls_ff;
   logic [7:0]  hdl_ff;
   logic [9:0]  len_ff;
   logic [63:0] now_ff;
   logic [31:0] life_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         id_ff   <= req_msg_id;
         cls_ff  <= req_message_class;
         hdl_ff  <= req_frame_handle;
         len_ff  <= req_frame_length;
         now_ff  <= req_now_ms;
         life_ff <= req_lifetime_ms;
      end
   end

   // entry table
   logic [MAX_ENTRIES-1:0] used_ff;
   logic [31:0] eid_ff  [MAX_ENTRIES];
   logic [2:0]  ecls_ff [MAX_ENTRIES];
   logic [1:0]  epri_ff [MAX_ENTRIES];
   logic [7:0]  ehdl_ff [MAX_ENTRIES];
   logic [9:0]  elen_ff [MAX_ENTRIES];
   logic [63:0] ecre_ff [MAX_ENTRIES];
   logic [63:0] eexp_ff [MAX_ENTRIES];
   logic [63:0] eseq_ff [MAX_ENTRIES];
   logic [63:0] seq_ff;
   logic [4:0]  held_ff, held_in;

   // rate windows
   logic [63:0] rstart_ff [NUM_PRIORITIES];
   logic [7:0]  racc_ff   [NUM_PRIORITIES];
   logic [NUM_PRIORITIES-1:0] rstarted_ff;

   // event ring
   logic [31:0] evid_ff  [EVENT_DEPTH];
   logic [2:0]  evcls_ff [EVENT_DEPTH];
   logic [1:0]  evpri_ff [EVENT_DEPTH];
   logic        evrsn_ff [EVENT_DEPTH];
   logic [EV_W-1:0] ev_head_ff, ev_tail_ff;
   logic [3:0]  ev_cnt_ff;

   // scan state
   logic [IDX_W-1:0] idx_ff, vic_idx_ff, sel_idx_ff;
   logic        dup_ff, vic_found_ff, sel_found_ff;
   logic [4:0]  nu_ff;
   logic [1:0]  vic_pri_ff, sel_pri_ff;
   logic [63:0] vic_seq_ff, sel_seq_ff;
   logic [31:0] vic_id_ff;
   logic [2:0]  vic_cls_ff;
   logic [63:0] exp_ff;
   logic        rate_new_ff;

   res_type res_ff;

   // request derived values
   logic [15:0] map_ext;
   logic [1:0]  req_pri;
   logic [7:0]  rmax_sel;
   logic [15:0] rwin_sel;
   logic        policy_ok, arg_bad;
   status_type  chk_status;
   logic [64:0] exp_sum;

   always_comb begin
      map_ext  = {4'd0, map_ff};
      req_pri  = map_ext[{cls_ff, 1'b0} +: 2];
      rmax_sel = rmax_ff[{req_pri, 3'd0} +: 8];
      rwin_sel = rwin_ff[{req_pri, 4'd0} +: 16];
      policy_ok = (cap_ff != 5'd0) && (cap_ff <= 5'(MAX_ENTRIES)) && (rsv_ff <= cap_ff);
      for (int p = 0; p < NUM_PRIORITIES; p++) begin
         if (rmax_ff[p*8 +: 8] == 8'd0 || rwin_ff[p*16 +: 16] == 16'd0) begin
            policy_ok = 1'b0;
         end
      end
      arg_bad = (id_ff == 32'd0) || (cls_ff > 3'd5) || (len_ff == 10'd0) ||
                (life_ff == 32'd0);
      if (!policy_ok) begin
         chk_status = ST_POLICY;
      end else if (arg_bad) begin
         chk_status = ST_ARG;
      end else if (len_ff > 10'(MAX_FRAME_BYTES)) begin
         chk_status = ST_LARGE;
      end else begin
         chk_status = ST_OK;
      end
      exp_sum = {1'b0, now_ff} + {33'd0, life_ff};
   end

   // entry under scan or selected for take
   logic [IDX_W-1:0] rd_idx;
   logic        e_used, expired, live, better_vic, better_sel;
   logic [31:0] e_id;
   logic [2:0]  e_cls;
   logic [1:0]  e_pri;
   logic [63:0] e_seq;

   always_comb begin
      rd_idx  = cmd.take ? sel_idx_ff : idx_ff;
      e_used  = used_ff[rd_idx];
      e_id    = eid_ff[rd_idx];
      e_cls   = ecls_ff[rd_idx];
      e_pri   = epri_ff[rd_idx];
      e_seq   = eseq_ff[rd_idx];
      expired = e_used && (now_ff >= eexp_ff[rd_idx]);
      live    = e_used && !expired;
      better_vic = live && (req_pri < e_pri) &&
                   (!vic_found_ff || e_pri > vic_pri_ff ||
                    (e_pri == vic_pri_ff && e_seq < vic_seq_ff));
      better_sel = live &&
                   (!sel_found_ff || e_pri < sel_pri_ff ||
                    (e_pri == sel_pri_ff && e_seq < sel_seq_ff));
   end

   // enqueue decision
   logic [7:0]  rate_acc;
   logic        rate_fail, full, use_vic, rsv_fail, free_any, commit, drop_vic;
   logic [5:0]  nonurg;
   logic [MAX_ENTRIES-1:0] free_mask, vic_mask, slot_mask;
   logic [IDX_W-1:0] slot;
   status_type  dec_status;

   always_comb begin
      rate_acc  = rate_new_ff ? 8'd0 : racc_ff[req_pri];
      rate_fail = rate_acc >= rmax_sel;
      full      = held_ff >= cap_ff;
      use_vic   = full && vic_found_ff;
      nonurg    = 6'd1 + {1'b0, nu_ff} - {5'd0, (use_vic && vic_pri_ff > 2'd1)};
      rsv_fail  = (req_pri > 2'd1) && (rsv_ff != 5'd0) &&
                  (nonurg > {1'b0, cap_ff - rsv_ff});
      free_mask = ~used_ff;
      if (use_vic) begin
         free_mask[vic_idx_ff] = 1'b1;
      end
      free_any = 1'b0;
      slot     = '0;
      for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
         if (free_mask[i]) begin
            free_any = 1'b1;
            slot     = IDX_W'(i);
         end
      end
      commit   = 1'b0;
      if (dup_ff) begin
         dec_status = ST_DUP;
      end else if (rate_fail) begin
         dec_status = ST_RATE;
      end else if (full && !vic_found_ff) begin
         dec_status = ST_FULL;
      end else if (rsv_fail) begin
         dec_status = ST_RESERVED;
      end else if (!free_any) begin
         dec_status = ST_FULL;
      end else begin
         dec_status = ST_OK;
         commit     = 1'b1;
      end
      drop_vic = commit && use_vic;
      vic_mask = '0;
      if (drop_vic) begin
         vic_mask[vic_idx_ff] = 1'b1;
      end
      slot_mask       = '0;
      slot_mask[slot] = 1'b1;
   end

   // event push and entry drop
   logic        ev_push, ev_pop, drop_one;
   logic [31:0] push_id;
   logic [2:0]  push_cls;
   logic [1:0]  push_pri;

   always_comb begin
      ev_push  = ((cmd.scan && expired) || (cmd.decide && drop_vic)) &&
                 (ev_cnt_ff < 4'(EVENT_DEPTH));
      ev_pop   = cmd.pop && (ev_cnt_ff != 4'd0);
      push_id  = cmd.decide ? vic_id_ff  : e_id;
      push_cls = cmd.decide ? vic_cls_ff : e_cls;
      push_pri = cmd.decide ? vic_pri_ff : e_pri;
      drop_one = (cmd.scan && expired) || (cmd.decide && drop_vic) ||
                 (cmd.take && sel_found_ff);
      held_in  = held_ff - {4'd0, (drop_one && held_ff != 5'd0)} +
                 {4'd0, (cmd.decide && commit)};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff     <= '0;
         held_ff     <= '0;
         seq_ff      <= '0;
         rstarted_ff <= '0;
         ev_head_ff  <= '0;
         ev_tail_ff  <= '0;
         ev_cnt_ff   <= '0;
         for (int p = 0; p < NUM_PRIORITIES; p++) begin
            rstart_ff[p] <= '0;
            racc_ff[p]   <= '0;
         end
      end else begin
         held_ff <= held_in;
         if (cmd.scan && expired) begin
            used_ff[idx_ff] <= 1'b0;
         end
         if (cmd.take && sel_found_ff) begin
            used_ff[sel_idx_ff] <= 1'b0;
         end
         if (cmd.decide && !dup_ff && rate_new_ff) begin
            rstart_ff[req_pri]   <= now_ff;
            rstarted_ff[req_pri] <= 1'b1;
         end
         if (cmd.decide && commit) begin
            used_ff          <= (used_ff & ~vic_mask) | slot_mask;
            seq_ff           <= seq_ff + 64'd1;
            racc_ff[req_pri] <= rate_acc + 8'd1;
         end else if (cmd.decide && !dup_ff && rate_new_ff) begin
            racc_ff[req_pri] <= 8'd0;
         end
         if (ev_push) begin
            ev_tail_ff <= ev_tail_ff + EV_W'(1);
            ev_cnt_ff  <= ev_cnt_ff + 4'd1;
         end
         if (ev_pop) begin
            ev_head_ff <= ev_head_ff + EV_W'(1);
            ev_cnt_ff  <= ev_cnt_ff - 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.decide && commit) begin
         eid_ff[slot]  <= id_ff;
         ecls_ff[slot] <= cls_ff;
         epri_ff[slot] <= req_pri;
         ehdl_ff[slot] <= hdl_ff;
         elen_ff[slot] <= len_ff;
         ecre_ff[slot] <= now_ff;
         eexp_ff[slot] <= exp_ff;
         eseq_ff[slot] <= seq_ff;
      end
      if (ev_push) begin
         evid_ff[ev_tail_ff]  <= push_id;
         evcls_ff[ev_tail_ff] <= push_cls;
         evpri_ff[ev_tail_ff] <= push_pri;
         evrsn_ff[ev_tail_ff] <= cmd.decide;
      end
      if (cmd.check) begin
         exp_ff      <= exp_sum[64] ? '1 : exp_sum[63:0];
         rate_new_ff <= !rstarted_ff[req_pri] || (now_ff < rstart_ff[req_pri]) ||
                        ((now_ff - rstart_ff[req_pri]) >= {48'd0, rwin_sel});
      end
      if (cmd.scan && better_vic) begin
         vic_idx_ff <= idx_ff;
         vic_pri_ff <= e_pri;
         vic_seq_ff <= e_seq;
         vic_id_ff  <= e_id;
         vic_cls_ff <= e_cls;
      end
      if (cmd.scan && better_sel) begin
         sel_idx_ff <= idx_ff;
         sel_pri_ff <= e_pri;
         sel_seq_ff <= e_seq;
      end
   end

   // scan control
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         dup_ff       <= 1'b0;
         nu_ff        <= '0;
         vic_found_ff <= 1'b0;
         sel_found_ff <= 1'b0;
      end else if (cmd.load) begin
         idx_ff       <= '0;
         dup_ff       <= 1'b0;
         nu_ff        <= '0;
         vic_found_ff <= 1'b0;
         sel_found_ff <= 1'b0;
      end else if (cmd.scan) begin
         idx_ff <= idx_ff + IDX_W'(1);
         if (live && e_id == id_ff) begin
            dup_ff <= 1'b1;
         end
         if (live && e_pri > 2'd1) begin
            nu_ff <= nu_ff + 5'd1;
         end
         if (better_vic) begin
            vic_found_ff <= 1'b1;
         end
         if (better_sel) begin
            sel_found_ff <= 1'b1;
         end
      end
   end

   // working result
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         res_ff <= '0;
      end
      if (cmd.check && chk_status != ST_OK) begin
         res_ff.status <= chk_status;
      end
      if (cmd.decide) begin
         res_ff.status <= dec_status;
         if (drop_vic) begin
            res_ff.result_valid <= 1'b1;
            res_ff.msg_id       <= vic_id_ff;
         end
      end
      if (cmd.take && sel_found_ff) begin
         res_ff.result_valid <= 1'b1;
         res_ff.msg_id       <= e_id;
         res_ff.msg_class    <= e_cls;
         res_ff.priority_lvl <= e_pri;
         res_ff.frame_handle <= ehdl_ff[rd_idx];
         res_ff.frame_length <= elen_ff[rd_idx];
         res_ff.created_ms   <= ecre_ff[rd_idx];
         res_ff.expires_ms   <= eexp_ff[rd_idx];
      end
      if (ev_pop) begin
         res_ff.result_valid <= 1'b1;
         res_ff.msg_id       <= evid_ff[ev_head_ff];
         res_ff.msg_class    <= evcls_ff[ev_head_ff];
         res_ff.priority_lvl <= evpri_ff[ev_head_ff];
         res_ff.event_reason <= evrsn_ff[ev_head_ff];
      end
   end

   // response register
   logic rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_res            <= res_ff;
         rsp_queued_count   <= held_ff;
         rsp_pending_events <= ev_cnt_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign sts.check_fail = (chk_status != ST_OK);
   assign sts.scan_last  = (idx_ff == IDX_W'(MAX_ENTRIES - 1));
   assign sts.rsp_busy   = rsp_valid_ff && !rsp_ready;

endmodule

>>> rtl/priority_message_queue_with_rate_limit.sv
// Top level of the priority message queue with per-priority rate limit.
// Joins pmqrl_ctrl and pmqrl_dp; depends on pmqrl_pkg.
//
//   channel   direction  handshake              contents
//   req_*     in         req_valid / req_ready  action and message fields
//   rsp_*     out        rsp_valid / rsp_ready  result, status and counts
//   csr_*     in         csr_we                 policy register writes
//
// Enqueue: check, a scan of all 16 table entries, decision, finish. Take: scan,
// take, finish. An enqueue rejected by the policy, argument or size check goes
// from check to finish; a pop goes through pop to finish, no action to finish.
// Reset is synchronous and clears the table, rate windows and event ring.
// A request is accepted while a finished response still waits; the next
// response holds until the waiting one is taken.
module priority_message_queue_with_rate_limit import pmqrl_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_action,
   input  logic [31:0] req_msg_id,
   input  logic [2:0]  req_message_class,
   input  logic [7:0]  req_frame_handle,
   input  logic [9:0]  req_frame_length,
   input  logic [63:0] req_now_ms,
   input  logic [31:0] req_lifetime_ms,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_result_valid,
   output logic [2:0]  rsp_status_code,
   output logic [31:0] rsp_out_msg_id,
   output logic [2:0]  rsp_out_class,
   output logic [1:0]  rsp_out_priority,
   output logic [7:0]  rsp_out_frame_handle,
   output logic [9:0]  rsp_out_frame_length,
   output logic [63:0] rsp_out_created_ms,
   output logic [63:0] rsp_out_expires_ms,
   output logic        rsp_event_reason,
   output logic [4:0]  rsp_queued_count,
   output logic [3:0]  rsp_pending_events,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata
);

   cmd_type cmd;
   sts_type sts;
   res_type res;

   pmqrl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_action (req_action),
      .sts        (sts),
      .cmd        (cmd)
   );

   pmqrl_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_msg_id         (req_msg_id),
      .req_message_class  (req_message_class),
      .req_frame_handle   (req_frame_handle),
      .req_frame_length   (req_frame_length),
      .req_now_ms         (req_now_ms),
      .req_lifetime_ms    (req_lifetime_ms),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_res            (res),
      .rsp_queued_count   (rsp_queued_count),
      .rsp_pending_events (rsp_pending_events)
   );

   assign rsp_result_valid     = res.result_valid;
   assign rsp_status_code      = res.status;
   assign rsp_out_msg_id       = res.msg_id;
   assign rsp_out_class        = res.msg_class;
   assign rsp_out_priority     = res.priority_lvl;
   assign rsp_out_frame_handle = res.frame_handle;
   assign rsp_out_frame_length = res.frame_length;
   assign rsp_out_created_ms   = res.created_ms;
   assign rsp_out_expires_ms   = res.expires_ms;
   assign rsp_event_reason     = res.event_reason;

endmodule

>>> rtl/pmqrl_checker.sv
// Port checker for the priority message queue, bound to the top level.
// Depends on pmqrl_pkg.
module pmqrl_checker import pmqrl_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_result_valid,
   input logic [2:0]  rsp_status_code,
   input logic [31:0] rsp_out_msg_id,
   input logic        rsp_event_reason,
   input logic [4:0]  rsp_queued_count,
   input logic [3:0]  rsp_pending_events
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_msg_id))
      else $error("response changed while stalled");

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_queued_count <= 5'(MAX_ENTRIES))
      else $error("queued count above table size");

   a_ring_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_pending_events <= 4'(EVENT_DEPTH))
      else $error("event count above ring depth");

   a_reject_no_preempt: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status_code != ST_OK |-> !rsp_result_valid)
      else $error("rejected enqueue reports a preemption");

   a_reason_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_reason |-> rsp_result_valid)
      else $error("event reason without an event");

endmodule

bind priority_message_queue_with_rate_limit pmqrl_checker u_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_result_valid   (rsp_result_valid),
   .rsp_status_code    (rsp_status_code),
   .rsp_out_msg_id     (rsp_out_msg_id),
   .rsp_event_reason   (rsp_event_reason),
   .rsp_queued_count   (rsp_queued_count),
   .rsp_pending_events (rsp_pending_events)
);
